// ===== hw/rtl/mcr_pkg.sv =====
// shared types and constants for the midpoint circle rasterizer
package mcr_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 240;
  localparam int unsigned SCREEN_HEIGHT_DEF = 240;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned OFFSET_W = 11;
  localparam int unsigned RADIUS_W = 10;
  localparam int unsigned DEC_W    = 14;
  localparam int unsigned DATA_W   = 16;

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_START   = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [OFFSET_W-1:0] x;
    logic signed [OFFSET_W-1:0] y;
    logic [DATA_W-1:0]          pixel;
    logic                       done;
  } step_t;

  typedef struct packed {
    logic push;
  } queue_ctl_t;

endpackage

// ===== hw/rtl/mcr_front.sv =====
// front end: accepts transactions, holds the circle state and issues one step descriptor per step
module mcr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic signed [mcr_pkg::COORD_W-1:0]  in_center_x,
  input  logic signed [mcr_pkg::COORD_W-1:0]  in_center_y,
  input  logic [mcr_pkg::RADIUS_W-1:0]        in_radius,
  input  logic [mcr_pkg::DATA_W-1:0]          in_color,
  output mcr_pkg::queue_ctl_t                 ctl_o,
  input  logic                                full_i,
  output mcr_pkg::step_t                      step_o
);

  logic signed [mcr_pkg::COORD_W-1:0]  cx_r, cx_nxt;
  logic signed [mcr_pkg::COORD_W-1:0]  cy_r, cy_nxt;
  logic [mcr_pkg::DATA_W-1:0]          color_r, color_nxt;
  logic signed [mcr_pkg::OFFSET_W-1:0] x_r, x_nxt;
  logic signed [mcr_pkg::OFFSET_W-1:0] y_r, y_nxt;
  logic signed [mcr_pkg::DEC_W-1:0]    d_r, d_nxt;
  logic                                act_r, act_nxt;

  logic                                accept;
  logic signed [mcr_pkg::COORD_W-1:0]  cx_l, cy_l;
  logic [mcr_pkg::DATA_W-1:0]          color_l;
  logic signed [mcr_pkg::OFFSET_W-1:0] x_l, y_l, x_u, y_u;
  logic signed [mcr_pkg::DEC_W-1:0]    d_l;
  logic                                act_l, emit, done;

  assign accept   = in_valid && !full_i;
  assign in_stall = full_i;

  always_comb begin
    if (mcr_pkg::op_t'(in_op) == mcr_pkg::OP_START) begin
      cx_l    = in_center_x;
      cy_l    = in_center_y;
      color_l = in_color;
      x_l     = '0;
      y_l     = $signed(mcr_pkg::OFFSET_W'(in_radius));
      d_l     = mcr_pkg::DEC_W'(1) - $signed(mcr_pkg::DEC_W'(in_radius));
      act_l   = 1'b1;
    end else begin
      cx_l    = cx_r;
      cy_l    = cy_r;
      color_l = color_r;
      x_l     = x_r;
      y_l     = y_r;
      d_l     = d_r;
      act_l   = act_r;
    end
    emit = act_l && !(x_l > y_l);
    if (d_l < 0) begin
      d_nxt = d_l + (mcr_pkg::DEC_W'(x_l) <<< 1) + mcr_pkg::DEC_W'(3);
      y_u   = y_l;
    end else begin
      d_nxt = d_l + ((mcr_pkg::DEC_W'(x_l) - mcr_pkg::DEC_W'(y_l)) <<< 1)
              + mcr_pkg::DEC_W'(5);
      y_u   = y_l - mcr_pkg::OFFSET_W'(1);
    end
    x_u  = x_l + mcr_pkg::OFFSET_W'(1);
    done = x_u > y_u;

    cx_nxt    = cx_l;
    cy_nxt    = cy_l;
    color_nxt = color_l;
    if (emit) begin
      x_nxt   = x_u;
      y_nxt   = y_u;
      act_nxt = !done;
    end else begin
      x_nxt   = x_l;
      y_nxt   = y_l;
      d_nxt   = d_l;
      act_nxt = 1'b0;
    end
  end

  assign ctl_o.push  = accept && emit;
  assign step_o.cx    = cx_l;
  assign step_o.cy    = cy_l;
  assign step_o.x     = x_l;
  assign step_o.y     = y_l;
  assign step_o.pixel = {color_l[7:0], color_l[15:8]};
  assign step_o.done  = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      color_r <= '0;
      x_r     <= '0;
      y_r     <= '0;
      d_r     <= '0;
      act_r   <= 1'b0;
    end else if (accept) begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      color_r <= color_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      d_r     <= d_nxt;
      act_r   <= act_nxt;
    end
  end

endmodule

// ===== hw/rtl/mcr_queue.sv =====
// short queue of step descriptors between front and back
module mcr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  mcr_pkg::queue_ctl_t ctl_i,
  input  mcr_pkg::step_t      wr_data,
  output logic                full_o,
  output logic                empty_o,
  input  logic                pop,
  output mcr_pkg::step_t      rd_data
);

  localparam int unsigned PTR_W = (mcr_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(mcr_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(mcr_pkg::QUEUE_DEPTH + 1);

  mcr_pkg::step_t   mem_r [mcr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == CNT_W'(mcr_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = ctl_i.push && !full_o;
  assign do_pop  = pop && !empty_o;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt = (wp_r == PTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    rp_nxt = (rp_r == PTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_nxt;
      end
      if (do_pop) begin
        rp_r <= rp_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/mcr_back.sv =====
// back end: walks the eight octant points of a step and drives the result register
module mcr_back #(
  parameter int unsigned SCREEN_WIDTH  = mcr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = mcr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        empty_i,
  input  mcr_pkg::step_t              step_i,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mcr_pkg::DATA_W-1:0]  out_fb_address,
  output logic [mcr_pkg::DATA_W-1:0]  out_pixel_word,
  output logic                        out_visible,
  output logic                        out_step_last,
  output logic                        out_circle_done
);

  localparam int unsigned PW = mcr_pkg::COORD_W + 2;
  localparam logic signed [PW-1:0] WIDTH_S  = PW'(SCREEN_WIDTH);
  localparam logic signed [PW-1:0] HEIGHT_S = PW'(SCREEN_HEIGHT);
  localparam int unsigned PRODW = mcr_pkg::RADIUS_W + PW;

  mcr_pkg::step_t              cur_r;
  logic                        busy_r;
  logic [2:0]                  k_r;
  logic                        ov_r;
  logic [mcr_pkg::DATA_W-1:0]  addr_r, pix_r;
  logic                        vis_r, last_r, done_r;

  logic                        load, finish;
  logic signed [PW-1:0]        a, b, px, py;
  logic                        vis;
  logic [PRODW-1:0]            addr_full;

  assign load   = busy_r && (!ov_r || !out_stall);
  assign finish = load && (k_r == 3'd7);
  assign pop    = !empty_i && (!busy_r || finish);

  always_comb begin
    a  = k_r[2] ? PW'(cur_r.y) : PW'(cur_r.x);
    b  = k_r[2] ? PW'(cur_r.x) : PW'(cur_r.y);
    px = PW'(cur_r.cx) + (k_r[0] ? -a : a);
    py = PW'(cur_r.cy) + (k_r[1] ? -b : b);
    vis = (px >= 0) && (px < WIDTH_S) && (py >= 0) && (py < HEIGHT_S);
    addr_full = PRODW'(py[mcr_pkg::RADIUS_W-1:0]) * PRODW'(SCREEN_WIDTH)
                + PRODW'(px[mcr_pkg::RADIUS_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= step_i;
    end
    if (load) begin
      addr_r <= vis ? addr_full[mcr_pkg::DATA_W-1:0] : '0;
      pix_r  <= cur_r.pixel;
      vis_r  <= vis;
      last_r <= (k_r == 3'd7);
      done_r <= (k_r == 3'd7) && cur_r.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (finish) begin
        busy_r <= 1'b0;
      end else if (load) begin
        k_r <= k_r + 3'd1;
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_fb_address  = addr_r;
  assign out_pixel_word  = pix_r;
  assign out_visible     = vis_r;
  assign out_step_last   = last_r;
  assign out_circle_done = done_r;

endmodule

// ===== hw/rtl/midpoint_circle_rasterizer.sv =====
// top level of the midpoint circle rasterizer
// A start transaction loads centre, radius and colour and produces the first step of the
// circle; each advance transaction produces the next step. Every step yields eight point
// transactions, one per cycle while out_stall is low, from the single point generator in
// the back end. A two-entry step queue sits between the front end, which runs the
// decision-term update combinationally for each transaction, and the back end, so new
// transactions are taken while points are still being emitted. Points off screen come
// out with visible low and address zero; the step's eighth point carries step_last, and
// on the final step circle_done as well.
module midpoint_circle_rasterizer #(
  parameter int unsigned SCREEN_WIDTH  = mcr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = mcr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic signed [mcr_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [mcr_pkg::COORD_W-1:0] in_center_y,
  input  logic [mcr_pkg::RADIUS_W-1:0]       in_radius,
  input  logic [mcr_pkg::DATA_W-1:0]         in_color,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mcr_pkg::DATA_W-1:0]         out_fb_address,
  output logic [mcr_pkg::DATA_W-1:0]         out_pixel_word,
  output logic                               out_visible,
  output logic                               out_step_last,
  output logic                               out_circle_done
);

  mcr_pkg::queue_ctl_t ctl;
  mcr_pkg::step_t      wr_step, rd_step;
  logic                full, empty, pop;

  mcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .in_color    (in_color),
    .ctl_o       (ctl),
    .full_i      (full),
    .step_o      (wr_step)
  );

  mcr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl),
    .wr_data (wr_step),
    .full_o  (full),
    .empty_o (empty),
    .pop     (pop),
    .rd_data (rd_step)
  );

  mcr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty_i         (empty),
    .step_i          (rd_step),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fb_address  (out_fb_address),
    .out_pixel_word  (out_pixel_word),
    .out_visible     (out_visible),
    .out_step_last   (out_step_last),
    .out_circle_done (out_circle_done)
  );

endmodule
